// ===== hdl/command_history_ring_top_defines.svh =====
// assertion macros for the command history ring
`ifndef COMMAND_HISTORY_RING_TOP_DEFINES_SVH
`define COMMAND_HISTORY_RING_TOP_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define CHR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define CHR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/chr_pkg.sv =====
// shared types and opcodes for the command history ring
package chr_pkg;

  typedef logic [7:0] byte_t;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_RECALL = 1'b1;

endpackage

// ===== hdl/chr_if.sv =====
// valid/ready channel interfaces for command and line transactions
interface chr_in_if;
  import chr_pkg::*;

  logic  valid;
  logic  ready;
  logic  opcode;
  byte_t data_byte;
  byte_t entries_back;

  modport source (output valid, output opcode, output data_byte, output entries_back,
                  input ready);
  modport sink   (input valid, input opcode, input data_byte, input entries_back,
                  output ready);
endinterface

interface chr_out_if;
  import chr_pkg::*;

  logic  valid;
  logic  ready;
  byte_t line_byte;
  logic  last_flag;

  modport source (output valid, output line_byte, output last_flag, input ready);
  modport sink   (input valid, input line_byte, input last_flag, output ready);
endinterface

// ===== hdl/chr_mem.sv =====
// byte ring storage, one write port and one registered read port
module chr_mem #(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  chr_pkg::byte_t      wdata,
  input  logic                re,
  input  logic [ADDR_W-1:0]   raddr,
  output chr_pkg::byte_t      rdata
);
  import chr_pkg::*;

  byte_t mem [DEPTH];
  byte_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ===== hdl/command_history_ring_top.sv =====
// command history ring: byte ring with append and backward line recall
//
//  channel   dir   transaction
//  in_chan   in    append one byte or recall a line (opcode, data_byte, entries_back)
//  out_chan  out   one byte of a recalled line (line_byte, last_flag)
//
// after reset a clearing pass writes zeros over every ring entry, in_chan not ready
// append: writes data_byte at the write pointer and advances it
// recall: a backward search over the ring memory, then emission of the line byte by byte
// the single read port of the ring memory sets the step rate; out_chan stalls hold emission
// a finished byte waits in the output register while the next command is taken
module command_history_ring_top #(
  parameter int RING_DEPTH = 128,
  parameter int MAX_LINE   = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  chr_in_if.sink           in_chan,
  chr_out_if.source        out_chan
);
  import chr_pkg::*;

  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int STEP_W = $clog2(RING_DEPTH + 1);
  localparam int CNT_W  = $clog2(MAX_LINE);

  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(RING_DEPTH - 1);
  localparam logic [STEP_W-1:0] STEP_FULL = STEP_W'(RING_DEPTH);
  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(MAX_LINE - 1);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0]        state_r,  state_nxt;
  logic [PTR_W-1:0]  wp_r,     wp_nxt;
  logic [PTR_W-1:0]  pos_r,    pos_nxt;
  logic [STEP_W-1:0] steps_r,  steps_nxt;
  byte_t             rem_r,    rem_nxt;
  logic [CNT_W-1:0]  cnt_r,    cnt_nxt;
  logic              ovalid_r, ovalid_nxt;
  byte_t             obyte_r,  obyte_nxt;
  logic              olast_r,  olast_nxt;

  logic              mem_we;
  logic [PTR_W-1:0]  mem_waddr;
  byte_t             mem_wdata;
  logic              mem_re;
  logic [PTR_W-1:0]  mem_raddr;
  byte_t             mem_rdata;

  logic              in_acc;
  logic              out_free;
  logic              found;
  logic              is_last;
  logic [PTR_W-1:0]  wp_prev;
  logic [PTR_W-1:0]  wp_next;
  logic [PTR_W-1:0]  pos_prev;
  logic [PTR_W-1:0]  pos_next;

  chr_mem #(
    .DEPTH  (RING_DEPTH),
    .ADDR_W (PTR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_chan.ready      = (state_r == ST_IDLE);
  assign in_acc             = in_chan.valid && (state_r == ST_IDLE);
  assign out_chan.valid     = ovalid_r;
  assign out_chan.line_byte = obyte_r;
  assign out_chan.last_flag = olast_r;
  assign out_free           = !ovalid_r || out_chan.ready;

  assign wp_prev  = (wp_r == '0) ? PTR_LAST : wp_r - 1'b1;
  assign wp_next  = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
  assign pos_prev = (pos_r == '0) ? PTR_LAST : pos_r - 1'b1;
  assign pos_next = (pos_r == PTR_LAST) ? '0 : pos_r + 1'b1;

  assign found   = (mem_rdata == 8'h00) || (steps_r == STEP_FULL);
  assign is_last = (mem_rdata == 8'h00) || (cnt_r == CNT_LAST);

  always_comb begin
    state_nxt  = state_r;
    wp_nxt     = wp_r;
    pos_nxt    = pos_r;
    steps_nxt  = steps_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = ovalid_r;
    obyte_nxt  = obyte_r;
    olast_nxt  = olast_r;
    mem_we     = 1'b0;
    mem_waddr  = wp_r;
    mem_wdata  = in_chan.data_byte;
    mem_re     = 1'b0;
    mem_raddr  = pos_prev;

    if (ovalid_r && out_chan.ready) begin
      ovalid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = 8'h00;
        pos_nxt   = pos_r + 1'b1;
        if (pos_r == PTR_LAST) begin
          pos_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_chan.opcode == OP_APPEND) begin
            mem_we = 1'b1;
            wp_nxt = wp_next;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = wp_prev;
            pos_nxt   = wp_prev;
            steps_nxt = STEP_W'(1);
            rem_nxt   = in_chan.entries_back;
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        mem_re = 1'b1;
        if (found && (rem_r == 8'h00)) begin
          mem_raddr = pos_next;
          pos_nxt   = pos_next;
          cnt_nxt   = '0;
          state_nxt = ST_EMIT;
        end else begin
          mem_raddr = pos_prev;
          pos_nxt   = pos_prev;
          if (found) begin
            rem_nxt   = rem_r - 1'b1;
            steps_nxt = STEP_W'(1);
          end else begin
            steps_nxt = steps_r + 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          obyte_nxt  = mem_rdata;
          olast_nxt  = is_last;
          cnt_nxt    = cnt_r + 1'b1;
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = pos_next;
            pos_nxt   = pos_next;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      wp_r     <= '0;
      pos_r    <= '0;
      steps_r  <= '0;
      rem_r    <= '0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wp_r     <= wp_nxt;
      pos_r    <= pos_nxt;
      steps_r  <= steps_nxt;
      rem_r    <= rem_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
  end
endmodule

// ===== hdl/chr_checker.sv =====
// port-level checks for the command history ring, bound to the top level
`include "command_history_ring_top_defines.svh"

module chr_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           in_opcode,
  input logic           out_valid,
  input logic           out_ready,
  input chr_pkg::byte_t out_line_byte,
  input logic           out_last_flag
);
  import chr_pkg::*;

  `CHR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_line_byte) && $stable(out_last_flag), "output transaction changed while stalled")
  `CHR_ASSERT_NEXT(a_recall_busy, in_valid && in_ready && (in_opcode == OP_RECALL), !in_ready, "command taken during recall")
  `CHR_ASSERT_NEXT(a_append_silent, in_valid && in_ready && (in_opcode == OP_APPEND) && !out_valid, !out_valid, "append produced output")
  `CHR_ASSERT_NOW(a_clear_after_reset, $past(!rst_n), !in_ready, "command taken during clearing pass")
endmodule

bind command_history_ring_top chr_checker u_chr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .in_opcode     (in_chan.opcode),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_line_byte (out_chan.line_byte),
  .out_last_flag (out_chan.last_flag)
);

// ===== sim/testbench.sv =====
// self-checking testbench for the command history ring: directed table, random traffic, then a long-line recall
module testbench;
  import chr_pkg::*;

  localparam int RING_DEPTH = 128;
  localparam int MAX_LINE   = 64;
  localparam int NUM_ROWS   = 18;

  typedef struct packed {
    byte_t line_byte;
    logic  last_flag;
  } line_beat_t;

  typedef struct packed {
    logic  op;
    byte_t data;
    byte_t back;
    logic  fixed;
    byte_t fixed_byte;
  } cmd_row_t;

  logic clk;
  logic rst_n;

  chr_in_if  in_chan ();
  chr_out_if out_chan ();

  command_history_ring_top #(
    .RING_DEPTH(RING_DEPTH),
    .MAX_LINE  (MAX_LINE)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  byte_t      hist_mem [RING_DEPTH];
  int         wr_ptr;
  line_beat_t line_beats_due [$];

  int     error_count;
  int     items_sent;
  int     send_gap_pct;
  int     recv_stall_pct;
  longint cycle_count = 0;
  longint cycle_budget;

  // op, data_byte, entries_back, fixed result, fixed byte (single terminator beat)
  cmd_row_t cmd_table [NUM_ROWS] = '{
    '{OP_RECALL, 8'h00, 8'd0,   1'b1, 8'h00},
    '{OP_RECALL, 8'h00, 8'd255, 1'b1, 8'h00},
    '{OP_APPEND, 8'hFF, 8'h00,  1'b0, 8'h00},
    '{OP_APPEND, 8'h01, 8'hFF,  1'b0, 8'h00},
    '{OP_APPEND, 8'h80, 8'h00,  1'b0, 8'h00},
    '{OP_APPEND, 8'h7F, 8'h55,  1'b0, 8'h00},
    '{OP_APPEND, 8'h00, 8'h00,  1'b0, 8'h00},
    '{OP_RECALL, 8'h00, 8'd1,   1'b0, 8'h00},
    '{OP_RECALL, 8'h00, 8'd0,   1'b1, 8'h00},
    '{OP_APPEND, 8'h00, 8'h00,  1'b0, 8'h00},
    '{OP_RECALL, 8'hFF, 8'd1,   1'b1, 8'h00},
    '{OP_RECALL, 8'h00, 8'd2,   1'b0, 8'h00},
    '{OP_APPEND, 8'h55, 8'h00,  1'b0, 8'h00},
    '{OP_APPEND, 8'hAA, 8'h00,  1'b0, 8'h00},
    '{OP_APPEND, 8'h00, 8'h00,  1'b0, 8'h00},
    '{OP_RECALL, 8'h00, 8'd3,   1'b0, 8'h00},
    '{OP_RECALL, 8'hFF, 8'd255, 1'b0, 8'h00},
    '{OP_RECALL, 8'hAB, 8'd2,   1'b0, 8'h00}
  };

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic void apply_history_cmd(input logic op, input byte_t data,
                                            input byte_t back);
    int         pos;
    int         k;
    int         steps;
    int         n;
    line_beat_t beat;
    if (op == OP_APPEND) begin
      hist_mem[wr_ptr] = data;
      wr_ptr = (wr_ptr + 1) % RING_DEPTH;
    end else begin
      pos = wr_ptr;
      for (k = 0; k <= int'(back); k++) begin
        for (steps = 1; steps <= RING_DEPTH; steps++) begin
          pos = (pos == 0) ? RING_DEPTH - 1 : pos - 1;
          if (hist_mem[pos] == 8'h00) break;
        end
      end
      pos = (pos + 1) % RING_DEPTH;
      for (n = 0; n < MAX_LINE; n++) begin
        beat.line_byte = hist_mem[pos];
        beat.last_flag = (hist_mem[pos] == 8'h00) || (n + 1 >= MAX_LINE);
        line_beats_due.push_back(beat);
        pos = (pos + 1) % RING_DEPTH;
        if (beat.last_flag) break;
      end
    end
  endfunction

  function automatic byte_t recall_depth();
    return ($urandom_range(7) == 0) ? byte_t'($urandom_range(255)) : byte_t'($urandom_range(5));
  endfunction

  task automatic send_cmd(input logic op, input byte_t data, input byte_t back,
                          input logic use_fixed, input byte_t fixed_byte);
    line_beat_t beat;
    cycle_budget += 200 + 4 * (RING_DEPTH + 1);
    if (op == OP_RECALL) cycle_budget += 4 * ((int'(back) + 1) * RING_DEPTH + MAX_LINE * 200);
    while ($urandom_range(99) < send_gap_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.opcode       <= op;
    in_chan.data_byte    <= data;
    in_chan.entries_back <= back;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    items_sent++;
    if (use_fixed) begin
      beat.line_byte = fixed_byte;
      beat.last_flag = 1'b1;
      line_beats_due.push_back(beat);
    end else begin
      apply_history_cmd(op, data, back);
    end
  endtask

  task automatic random_segment();
    int kind;
    int len;
    int i;
    kind = $urandom_range(99);
    if (kind < 60) begin
      len = $urandom_range(8, 0);
      for (i = 0; i < len; i++)
        send_cmd(OP_APPEND, byte_t'($urandom_range(255, 1)), byte_t'($urandom), 1'b0, 8'h00);
      send_cmd(OP_APPEND, 8'h00, byte_t'($urandom), 1'b0, 8'h00);
      if ($urandom_range(1) == 1)
        send_cmd(OP_RECALL, byte_t'($urandom), recall_depth(), 1'b0, 8'h00);
    end else if (kind < 85) begin
      send_cmd(OP_RECALL, byte_t'($urandom), recall_depth(), 1'b0, 8'h00);
    end else begin
      // noise: any opcode, any byte, any depth
      send_cmd(logic'($urandom_range(1)), byte_t'($urandom), byte_t'($urandom), 1'b0, 8'h00);
    end
  endtask

  task automatic check_line_beat(input byte_t got_byte, input logic got_last);
    line_beat_t want;
    if (line_beats_due.size() == 0) begin
      $error("unexpected transaction: line_byte %02h last_flag %0b", got_byte, got_last);
      error_count++;
    end else begin
      want = line_beats_due.pop_front();
      if (got_byte !== want.line_byte) begin
        $error("line_byte expected %02h actual %02h", want.line_byte, got_byte);
        error_count++;
      end
      if (got_last !== want.last_flag) begin
        $error("last_flag expected %0b actual %0b", want.last_flag, got_last);
        error_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      check_line_beat(out_chan.line_byte, out_chan.last_flag);
    out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > cycle_budget) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int r;
    int phase;
    int start;
    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.opcode       = OP_APPEND;
    in_chan.data_byte    = 8'h00;
    in_chan.entries_back = 8'h00;
    error_count          = 0;
    items_sent           = 0;
    send_gap_pct         = 0;
    recv_stall_pct       = 0;
    cycle_budget         = 1000 + 4 * RING_DEPTH;
    wr_ptr               = 0;
    for (r = 0; r < RING_DEPTH; r++) hist_mem[r] = 8'h00;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < NUM_ROWS; r++)
      send_cmd(cmd_table[r].op, cmd_table[r].data, cmd_table[r].back,
               cmd_table[r].fixed, cmd_table[r].fixed_byte);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 84; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 84; end
        default: begin send_gap_pct = 13; recv_stall_pct = 13; end
      endcase
      start = items_sent;
      while (items_sent - start < 8) random_segment();
    end

    // one line longer than MAX_LINE, then recall across the cut
    repeat (MAX_LINE + 1)
      send_cmd(OP_APPEND, byte_t'($urandom_range(255, 1)), byte_t'($urandom), 1'b0, 8'h00);
    send_cmd(OP_APPEND, 8'h00, byte_t'($urandom), 1'b0, 8'h00);
    send_cmd(OP_RECALL, byte_t'($urandom), 8'd1, 1'b0, 8'h00);
    send_cmd(OP_RECALL, byte_t'($urandom), 8'd0, 1'b0, 8'h00);
    send_cmd(OP_RECALL, byte_t'($urandom), 8'd255, 1'b0, 8'h00);

    in_chan.valid <= 1'b0;
    cycle_budget += 1000 + 4 * RING_DEPTH;
    while (line_beats_due.size() != 0) @(posedge clk);
    repeat (2 * RING_DEPTH) @(posedge clk);

    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/chr_pkg.sv
hdl/chr_if.sv
hdl/chr_mem.sv
hdl/command_history_ring_top.sv
hdl/chr_checker.sv
sim/testbench.sv
